[src/wpt_pkg.sv]
`timescale 1ns / 1ps
package wpt_pkg;

   // default quarter-wave table resolution
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int FIFO_DEPTH = 2;

   // pi/2 in Q2.30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Taylor divisors (2n)(2n+1) for n = 1..7
   localparam logic [63:0] TAYLOR_DIV [7] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
   };

   // one queued vertex with its looked-up sine and cosine (Q1.14)
   typedef struct packed {
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] sin_val;
      logic signed [15:0] cos_val;
      logic [15:0]        scale;
      logic               is_last;
   } vtx_type;

   // round(16384 * sin(k * pi / 2^(bits+1))), evaluated at elaboration only
   function automatic logic [14:0] quarter_sine(input int k, input int bits);
      logic [63:0] x;
      logic [63:0] term;
      longint      sum;
      logic [63:0] r;
      int          kk;
      kk = (k > (1 << bits)) ? (1 << bits) : k;
      x = (HALF_PI_Q30 * 64'(kk)) >> bits;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = ((term * x) >> 30) / TAYLOR_DIV[n - 1];
         if ((n % 2) == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (64'(sum) + 64'd32768) >> 16;
      if (r > 64'd16384) r = 64'd16384;
      return r[14:0];
   endfunction

endpackage

[src/wpt_req_if.sv]
`timescale 1ns / 1ps
interface wpt_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] vertex_x;
   logic signed [15:0] vertex_y;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [15:0]        angle;
   logic [15:0]        scale;
   logic               is_last;

   modport source (output valid, vertex_x, vertex_y, pos_x, pos_y, angle, scale, is_last,
                   input ready);
   modport sink (input valid, vertex_x, vertex_y, pos_x, pos_y, angle, scale, is_last,
                 output ready);
endinterface

[src/wpt_rsp_if.sv]
`timescale 1ns / 1ps
interface wpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] start_x;
   logic signed [15:0] start_y;
   logic signed [15:0] end_x;
   logic signed [15:0] end_y;
   logic               last_segment;

   modport source (output valid, start_x, start_y, end_x, end_y, last_segment,
                   input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, last_segment,
                 output ready);
endinterface

[src/wpt_front.sv]
`timescale 1ns / 1ps
// Accepts vertices, looks up sine and cosine, and queues them for the back end.
module wpt_front #(
   parameter int SINE_TABLE_BITS = wpt_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   wpt_req_if.sink           req_ch,
   output logic              q_valid,
   output wpt_pkg::vtx_type  q_data,
   input  logic              q_pop
);
   localparam int QS = 1 << SINE_TABLE_BITS;
   localparam int PH_W = SINE_TABLE_BITS + 2;
   localparam int DEPTH = wpt_pkg::FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // quarter-wave table, constant
   logic [14:0] sin_tbl [QS + 1];
   for (genvar g = 0; g <= QS; g++) begin : g_tbl
      assign sin_tbl[g] = wpt_pkg::quarter_sine(g, SINE_TABLE_BITS);
   end

   logic [PH_W-1:0]            phase;
   logic [1:0]                 quad_s;
   logic [1:0]                 quad_c;
   logic [SINE_TABLE_BITS:0]   idx_k;
   logic [SINE_TABLE_BITS:0]   idx_r;
   logic [14:0]                mag_k;
   logic [14:0]                mag_r;
   logic [14:0]                mag_s;
   logic [14:0]                mag_c;
   wpt_pkg::vtx_type           entry;

   // phase and quadrant split; cosine is sine one quadrant ahead
   always_comb begin
      phase  = req_ch.angle[15 -: PH_W];
      quad_s = phase[PH_W-1 -: 2];
      quad_c = quad_s + 2'd1;
      idx_k  = {1'b0, phase[SINE_TABLE_BITS-1:0]};
      idx_r  = (SINE_TABLE_BITS+1)'(QS) - idx_k;
      mag_k  = sin_tbl[idx_k];
      mag_r  = sin_tbl[idx_r];
      mag_s  = quad_s[0] ? mag_r : mag_k;
      mag_c  = quad_c[0] ? mag_r : mag_k;
      entry.vertex_x = req_ch.vertex_x;
      entry.vertex_y = req_ch.vertex_y;
      entry.pos_x    = req_ch.pos_x;
      entry.pos_y    = req_ch.pos_y;
      entry.scale    = req_ch.scale;
      entry.is_last  = req_ch.is_last;
      entry.sin_val  = quad_s[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
      entry.cos_val  = quad_c[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
   end

   // small queue between front and back
   wpt_pkg::vtx_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              push;
   logic              pop;

   assign req_ch.ready = (cnt_ff != CNT_W'(DEPTH));
   assign push = req_ch.valid && req_ch.ready;
   assign pop  = q_pop && (cnt_ff != '0);
   assign q_valid = (cnt_ff != '0);
   assign q_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ((wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1)
                       : wr_ptr_ff;
      rd_ptr_in = pop ? ((rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1)
                      : rd_ptr_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= entry;
   end
endmodule

[src/wpt_back.sv]
`timescale 1ns / 1ps
// Rotates, scales, translates one queued vertex and emits its segments.
module wpt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  wpt_pkg::vtx_type  q_data,
   output logic              q_pop,
   wpt_rsp_if.source         rsp_ch
);
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ROT   = 6'b000010,
      ST_SCL   = 6'b000100,
      ST_FIN   = 6'b001000,
      ST_SEG   = 6'b010000,
      ST_CLOSE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   wpt_pkg::vtx_type   cur_ff;
   logic signed [32:0] rx_ff, ry_ff;
   logic signed [49:0] ax_ff, ay_ff;
   logic signed [15:0] tx_ff, ty_ff;
   logic signed [15:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic               have_first_ff;

   logic               out_valid_ff;
   logic signed [15:0] out_sx_ff, out_sy_ff, out_ex_ff, out_ey_ff;
   logic               out_last_ff;
   logic               out_free;
   logic               emit_seg;
   logic               emit_close;

   // round half up to Q12.4, add position, saturate
   function automatic logic signed [15:0] finish(input logic signed [49:0] acc,
                                                 input logic signed [15:0] pos);
      logic signed [49:0] biased;
      logic signed [24:0] sum;
      biased = acc + 50'sd33554432;
      sum = 25'($signed(biased[49:26])) + 25'(pos);
      if (sum > 25'sd32767) return 16'sh7fff;
      else if (sum < -25'sd32768) return 16'sh8000;
      else return sum[15:0];
   endfunction

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign emit_seg   = (state_ff == ST_SEG) && have_first_ff && out_free;
   assign emit_close = (state_ff == ST_CLOSE) && out_free;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) state_in = ST_ROT;
         ST_ROT:   state_in = ST_SCL;
         ST_SCL:   state_in = ST_FIN;
         ST_FIN:   state_in = ST_SEG;
         ST_SEG: begin
            if (!have_first_ff || out_free)
               state_in = cur_ff.is_last ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         have_first_ff <= 1'b0;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         // output register: load a new segment or retire the accepted one
         if (emit_seg || emit_close) out_valid_ff <= 1'b1;
         else if (rsp_ch.ready) out_valid_ff <= 1'b0;
         // record the first vertex of a polygon
         if ((state_ff == ST_SEG) && !have_first_ff) begin
            first_x_ff    <= tx_ff;
            first_y_ff    <= ty_ff;
            prev_x_ff     <= tx_ff;
            prev_y_ff     <= ty_ff;
            have_first_ff <= 1'b1;
         end
         // segment from previous vertex
         if (emit_seg) begin
            out_sx_ff    <= prev_x_ff;
            out_sy_ff    <= prev_y_ff;
            out_ex_ff    <= tx_ff;
            out_ey_ff    <= ty_ff;
            out_last_ff  <= 1'b0;
            prev_x_ff    <= tx_ff;
            prev_y_ff    <= ty_ff;
         end
         // closing segment back to the first vertex
         if (emit_close) begin
            out_sx_ff     <= tx_ff;
            out_sy_ff     <= ty_ff;
            out_ex_ff     <= first_x_ff;
            out_ey_ff     <= first_y_ff;
            out_last_ff   <= 1'b1;
            have_first_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_data;
      if (state_ff == ST_ROT) begin
         rx_ff <= 33'(cur_ff.vertex_x) * 33'(cur_ff.cos_val)
                  - 33'(cur_ff.vertex_y) * 33'(cur_ff.sin_val);
         ry_ff <= 33'(cur_ff.vertex_x) * 33'(cur_ff.sin_val)
                  + 33'(cur_ff.vertex_y) * 33'(cur_ff.cos_val);
      end
      if (state_ff == ST_SCL) begin
         ax_ff <= rx_ff * $signed({1'b0, cur_ff.scale});
         ay_ff <= ry_ff * $signed({1'b0, cur_ff.scale});
      end
      if (state_ff == ST_FIN) begin
         tx_ff <= finish(ax_ff, cur_ff.pos_x);
         ty_ff <= finish(ay_ff, cur_ff.pos_y);
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.start_x      = out_sx_ff;
   assign rsp_ch.start_y      = out_sy_ff;
   assign rsp_ch.end_x        = out_ex_ff;
   assign rsp_ch.end_y        = out_ey_ff;
   assign rsp_ch.last_segment = out_last_ff;
endmodule

[src/wireframe_polygon_transform_top.sv]
`timescale 1ns / 1ps
// Wireframe polygon transform. Each req transaction carries one Q12.4 model
// vertex with the object's position, binary angle and Q4.12 scale; the vertex
// is rotated (quarter-wave sine table, Q1.14), scaled, rounded, translated and
// saturated. Every vertex after the first of a polygon produces one rsp
// transaction, the segment from the previous vertex to itself; the vertex
// marked is_last also produces the closing segment back to the first vertex,
// flagged with last_segment. The front end looks up sine and cosine and
// queues two vertices; the back end handles one vertex at a time, stepping
// through pop, rotate, scale, round and emit, plus a closing step for a last
// vertex, and waits while the rsp side stalls on its output register.
module wireframe_polygon_transform_top #(
   parameter int SINE_TABLE_BITS = wpt_pkg::SINE_TABLE_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   wpt_req_if.sink   req_ch,
   wpt_rsp_if.source rsp_ch
);
   logic             q_valid;
   logic             q_pop;
   wpt_pkg::vtx_type q_data;

   wpt_front #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop)
   );

   wpt_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );
endmodule

[test/wireframe_polygon_transform_top_test.sv]
`timescale 1ns / 1ps
module wireframe_polygon_transform_top_test;

   localparam int TBITS = 10;
   localparam int QSTEPS = 1 << TBITS;

   typedef struct {
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] ex;
      logic signed [15:0] ey;
      logic               closing;
   } segment_type;

   // segment predictor and expected-segment store
   class segment_scoreboard;
      bit                 open_poly;
      logic signed [15:0] first_x, first_y, prev_x, prev_y;
      segment_type        pending[$];
      int                 errors;
      int                 sine_lut[QSTEPS + 1];

      function new();
         for (int k = 0; k <= QSTEPS; k++) sine_lut[k] = lut_entry(k);
      endfunction

      // quarter-wave entry, Q2.30 Taylor series rounded to Q1.14
      function int lut_entry(int k);
         longint unsigned x, term, r;
         longint sum;
         x = (64'd1686629713 * longint'(k)) >> TBITS;
         term = x;
         sum = x;
         for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2) sum -= term;
            else sum += term;
         end
         if (sum < 0) sum = 0;
         r = (longint'(sum) + 32768) >> 16;
         if (r > 16384) r = 16384;
         return int'(r);
      endfunction

      function int sine_at(int phase);
         int q, k, mag;
         phase = phase & (4 * QSTEPS - 1);
         q = phase >> TBITS;
         k = phase & (QSTEPS - 1);
         mag = (q & 1) ? sine_lut[QSTEPS - k] : sine_lut[k];
         return (q & 2) ? -mag : mag;
      endfunction

      // scale, round half up to Q12.4, translate, saturate
      function logic signed [15:0] place(longint rot, int scl, int pos);
         longint v;
         v = ((rot * scl + (64'sd1 <<< 25)) >>> 26) + pos;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return v[15:0];
      endfunction

      function void note_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                                logic signed [15:0] px, logic signed [15:0] py,
                                logic [15:0] ang, logic [15:0] scl, logic last);
         int ph, s, c;
         longint rx, ry;
         logic signed [15:0] tx, ty;
         segment_type seg;
         ph = ang >> (14 - TBITS);
         s = sine_at(ph);
         c = sine_at(ph + QSTEPS);
         rx = longint'(vx) * c - longint'(vy) * s;
         ry = longint'(vx) * s + longint'(vy) * c;
         tx = place(rx, scl, px);
         ty = place(ry, scl, py);
         if (!open_poly) begin
            first_x = tx;
            first_y = ty;
            open_poly = 1;
         end else begin
            seg = '{prev_x, prev_y, tx, ty, 1'b0};
            pending.insert(pending.size(), seg);
         end
         prev_x = tx;
         prev_y = ty;
         if (last) begin
            seg = '{tx, ty, first_x, first_y, 1'b1};
            pending.insert(pending.size(), seg);
            open_poly = 0;
         end
      endfunction

      function void check_segment(segment_type got);
         segment_type exp_seg;
         if (pending.size() == 0) begin
            $display("%0t: unexpected segment %p", $time, got);
            errors++;
            return;
         end
         exp_seg = pending.pop_front();
         if (got.sx !== exp_seg.sx || got.sy !== exp_seg.sy || got.ex !== exp_seg.ex ||
             got.ey !== exp_seg.ey || got.closing !== exp_seg.closing) begin
            $display("%0t: segment mismatch expected %p actual %p", $time, exp_seg, got);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   wpt_req_if req_ch ();
   wpt_rsp_if rsp_ch ();
   segment_scoreboard board;
   bit hold_off;

   wireframe_polygon_transform_top #(.SINE_TABLE_BITS(TBITS)) uut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // accept-side monitors
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         board.note_vertex(req_ch.vertex_x, req_ch.vertex_y, req_ch.pos_x, req_ch.pos_y,
                           req_ch.angle, req_ch.scale, req_ch.is_last);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_segment('{rsp_ch.start_x, rsp_ch.start_y, rsp_ch.end_x,
                               rsp_ch.end_y, rsp_ch.last_segment});
   end

   // one vertex transaction, optional idle gap before it
   task automatic send_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] px,
                              logic [15:0] py, logic [15:0] ang, logic [15:0] scl,
                              logic last, int gap);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.vertex_x <= vx;
      req_ch.vertex_y <= vy;
      req_ch.pos_x <= px;
      req_ch.pos_y <= py;
      req_ch.angle <= ang;
      req_ch.scale <= scl;
      req_ch.is_last <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [15:0] edge_val();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   // receiver: random stalls, one long hold-off
   initial begin
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ch.ready <= 0;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         if ($urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ch.ready <= 1;
      end
   end

   initial begin
      int quiet;
      int len;
      int g;
      board = new();
      reset = 1;
      req_ch.valid = 0;
      req_ch.vertex_x = 0;
      req_ch.vertex_y = 0;
      req_ch.pos_x = 0;
      req_ch.pos_y = 0;
      req_ch.angle = 0;
      req_ch.scale = 0;
      req_ch.is_last = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: single vertex, quadrant angles, extremes, saturation
      send_vertex(16'h0010, 16'h0020, 16'h0100, 16'h0200, 16'h0000, 16'h1000, 1, 0);
      send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h4000, 16'hFFFF, 0, 0);
      send_vertex(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 0, 0);
      send_vertex(16'h0100, 16'hFF00, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 0, 0);
      send_vertex(16'hFFFF, 16'h0001, 16'h1234, 16'hEDCB, 16'hFFFF, 16'h0001, 1, 0);
      send_vertex(16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h2000, 16'h1000, 0, 2);
      send_vertex(16'h0400, 16'h0400, 16'h0050, 16'hFFB0, 16'h0003, 16'h2000, 0, 0);
      send_vertex(16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h3FFF, 16'h8000, 1, 0);
      send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h6000, 16'hFFFF, 1, 0);

      // random polygons, mostly small coordinates, some extremes
      for (int i = 0; i < 1000; ) begin
         len = $urandom_range(1, 6);
         for (int j = 0; j < len; j++) begin
            if (i == 400) hold_off = 1;
            g = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
            if ((i / 150) % 2 == 1) g = 0;
            if ($urandom_range(0, 3) == 0)
               send_vertex(edge_val(), edge_val(), edge_val(), edge_val(),
                           16'($urandom()), edge_val(), j == len - 1, g);
            else
               send_vertex(16'($urandom_range(0, 2047) - 1024),
                           16'($urandom_range(0, 2047) - 1024),
                           16'($urandom_range(0, 8191) - 4096),
                           16'($urandom_range(0, 8191) - 4096),
                           16'($urandom()), 16'($urandom_range(0, 16'h3000)),
                           j == len - 1, g);
            i++;
         end
      end
      req_ch.valid <= 0;

      // drain
      quiet = 0;
      while (board.pending.size() != 0 && quiet < 20000) begin
         @(posedge clock);
         quiet++;
      end
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
